// ----- src/tdp_pkg.sv -----
// Shared types and constants of the teleinfo dataset parser.
// Used by the controller, the datapath and the top level; depends on nothing.
package tdp_pkg;

  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned SUM_W       = 6;

  localparam logic [CHAR_W-1:0] CH_STX     = 7'h02;
  localparam logic [CHAR_W-1:0] CH_ETX     = 7'h03;
  localparam logic [CHAR_W-1:0] CH_HT      = 7'h09;
  localparam logic [CHAR_W-1:0] CH_LF      = 7'h0A;
  localparam logic [CHAR_W-1:0] CH_CR      = 7'h0D;
  localparam logic [CHAR_W-1:0] CH_SP      = 7'h20;
  localparam logic [CHAR_W-1:0] CKS_OFFSET = 7'h20;

  typedef enum logic [1:0] {
    KIND_NAME,
    KIND_DATA,
    KIND_END,
    KIND_ERR
  } kind_e;

  typedef enum logic [2:0] {
    ERR_PARITY,
    ERR_FRAMING,
    ERR_TAG_LONG,
    ERR_CHECKSUM,
    ERR_SPLITTER,
    ERR_TOKEN_COUNT,
    ERR_OVERFLOW
  } err_e;

  typedef enum logic [1:0] {
    P_WAIT_STX,
    P_WAIT_LF,
    P_TAG,
    P_REST
  } parse_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_NAME_RD,
    S_NAME_WR,
    S_DATA_RD,
    S_DATA_WR
  } ctrl_e;

  typedef struct packed {
    logic  wr_en;
    logic  fill_clear;
    logic  tab_load;
    logic  scan_start;
    logic  scan_step;
    logic  name_init;
    logic  data_init;
    logic  rd_step;
    logic  out_load;
    kind_e out_kind;
    err_e  out_err;
    logic  out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic par_err;
    logic is_stx;
    logic is_etx;
    logic is_lf;
    logic is_cr;
    logic is_split;
    logic full;
    logic tag_full;
    logic out_free;
    logic scan_done;
    logic short_err;
    logic cks_err;
    logic tok_err;
    logic emit_more;
  } dp_sts_t;

endpackage

// ----- src/tdp_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependency.
module tdp_ram #(
  parameter int unsigned WIDTH = 7,
  parameter int unsigned DEPTH = 37
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- src/tdp_datapath.sv -----
// Datapath of the teleinfo parser: character store, fill count, checksum and
// splitter scan, emission range and the output register. Uses tdp_pkg, tdp_ram.
module tdp_datapath
  import tdp_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 37,
  parameter int unsigned TAG_MAX     = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [IN_TDATA_W-1:0] rx_byte_i,
  input  dp_cmd_t               cmd_i,
  output dp_sts_t               sts_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output kind_e                 out_kind_o,
  output logic [CHAR_W-1:0]     out_char_o,
  output err_e                  out_err_o,
  output logic                  out_last_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);

  logic [CHAR_W-1:0] rx_char;
  logic [CHAR_W-1:0] rdata;
  logic [CHAR_W-1:0] splitter;

  logic [CW-1:0] fill_q, fill_d;
  logic          tab_q, tab_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] end_q, end_d;
  logic          pend_q, pend_d;
  logic [CW-1:0] didx_q, didx_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [2:0]    cnt_q, cnt_d;
  logic [CW-1:0] pos0_q, pos0_d, pos1_q, pos1_d, pos2_q, pos2_d;
  logic [CHAR_W-1:0] lchar_q, lchar_d;

  logic              ovalid_q, ovalid_d;
  kind_e             okind_q, okind_d;
  logic [CHAR_W-1:0] ochar_q, ochar_d;
  err_e              oerr_q, oerr_d;
  logic              olast_q, olast_d;

  logic          scan_rd;
  logic          re;
  logic [CW:0]   j1, j2, fillx;
  logic          in_cov;
  logic [CW-1:0] data_start, data_end;

  assign rx_char  = rx_byte_i[CHAR_W-1:0];
  assign splitter = tab_q ? CH_HT : CH_SP;
  assign scan_rd  = cmd_i.scan_step && (idx_q < fill_q);
  assign re       = scan_rd || cmd_i.rd_step;

  tdp_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(fill_q[AW-1:0]),
    .wdata_i(rx_char),
    .re_i   (re),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(rdata)
  );

  assign fillx  = {1'b0, fill_q};
  assign j1     = {1'b0, didx_q} + (CW+1)'(1);
  assign j2     = {1'b0, didx_q} + (CW+1)'(2);
  assign in_cov = tab_q ? (j1 < fillx) : (j2 < fillx);

  assign data_start = (cnt_q == 3'd2) ? pos0_q + CW'(1) : pos1_q + CW'(1);
  assign data_end   = (cnt_q == 3'd2) ? pos1_q : pos2_q;

  always_comb begin
    fill_d  = fill_q;
    tab_d   = tab_q;
    idx_d   = idx_q;
    end_d   = end_q;
    pend_d  = scan_rd;
    didx_d  = idx_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    pos0_d  = pos0_q;
    pos1_d  = pos1_q;
    pos2_d  = pos2_q;
    lchar_d = lchar_q;

    if (cmd_i.fill_clear) begin
      fill_d = '0;
    end else if (cmd_i.wr_en) begin
      fill_d = fill_q + CW'(1);
    end
    if (cmd_i.tab_load) begin
      tab_d = (rx_char == CH_HT);
    end

    if (cmd_i.scan_start) begin
      idx_d  = '0;
      sum_d  = '0;
      cnt_d  = '0;
      pend_d = 1'b0;
    end else if (cmd_i.name_init) begin
      idx_d = '0;
      end_d = pos0_q;
    end else if (cmd_i.data_init) begin
      idx_d = data_start;
      end_d = data_end;
    end else if (re) begin
      idx_d = idx_q + CW'(1);
    end

    // One stored character comes back from the store per cycle of the scan.
    if (pend_q) begin
      if (in_cov) begin
        sum_d = sum_q + rdata[SUM_W-1:0];
      end
      if (j1 == fillx) begin
        lchar_d = rdata;
      end
      if ((j1 < fillx) && (rdata == splitter)) begin
        case (cnt_q)
          3'd0:    pos0_d = didx_q;
          3'd1:    pos1_d = didx_q;
          3'd2:    pos2_d = didx_q;
          default: ;
        endcase
        if (cnt_q < 3'd4) begin
          cnt_d = cnt_q + 3'd1;
        end
      end
    end
  end

  always_comb begin
    ovalid_d = ovalid_q;
    okind_d  = okind_q;
    ochar_d  = ochar_q;
    oerr_d   = oerr_q;
    olast_d  = olast_q;
    if (cmd_i.out_load) begin
      ovalid_d = 1'b1;
      okind_d  = cmd_i.out_kind;
      oerr_d   = cmd_i.out_err;
      olast_d  = cmd_i.out_last;
      ochar_d  = ((cmd_i.out_kind == KIND_NAME) || (cmd_i.out_kind == KIND_DATA)) ? rdata : '0;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      tab_q    <= 1'b0;
      idx_q    <= '0;
      end_q    <= '0;
      pend_q   <= 1'b0;
      didx_q   <= '0;
      sum_q    <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      tab_q    <= tab_d;
      idx_q    <= idx_d;
      end_q    <= end_d;
      pend_q   <= pend_d;
      didx_q   <= didx_d;
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos0_q  <= pos0_d;
    pos1_q  <= pos1_d;
    pos2_q  <= pos2_d;
    lchar_q <= lchar_d;
    okind_q <= okind_d;
    ochar_q <= ochar_d;
    oerr_q  <= oerr_d;
    olast_q <= olast_d;
  end

  always_comb begin
    sts_o.par_err   = ^rx_byte_i;
    sts_o.is_stx    = (rx_char == CH_STX);
    sts_o.is_etx    = (rx_char == CH_ETX);
    sts_o.is_lf     = (rx_char == CH_LF);
    sts_o.is_cr     = (rx_char == CH_CR);
    sts_o.is_split  = (rx_char == CH_HT) || (rx_char == CH_SP);
    sts_o.full      = (fill_q >= CW'(STORE_DEPTH));
    sts_o.tag_full  = ({{(32-CW){1'b0}}, fill_q} >= 32'(TAG_MAX));
    sts_o.out_free  = !ovalid_q || out_ready_i;
    sts_o.scan_done = !pend_q && (idx_q == fill_q);
    sts_o.short_err = !tab_q && (fill_q < CW'(2));
    sts_o.cks_err   = (CHAR_W'({1'b0, sum_q}) + CKS_OFFSET) != lchar_q;
    sts_o.tok_err   = (cnt_q != 3'd2) && (cnt_q != 3'd3);
    sts_o.emit_more = (idx_q < end_q);
  end

  assign out_valid_o = ovalid_q;
  assign out_kind_o  = okind_q;
  assign out_char_o  = ochar_q;
  assign out_err_o   = oerr_q;
  assign out_last_o  = olast_q;

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(STORE_DEPTH))
    else $error("fill count ran past the store depth");

  a_no_write_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> !sts_o.full)
    else $error("store written while full");

  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!ovalid_q || out_ready_i))
    else $error("output register overwritten while a beat waits");

  a_scan_read_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> !pend_q)
    else $error("store written while a scan read is in flight");

endmodule

// ----- src/tdp_ctrl.sv -----
// Controller of the teleinfo parser: frame parse state and the sequencer for
// the checksum scan and the emission of a finished dataset. Uses tdp_pkg.
module tdp_ctrl
  import tdp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_e  state_q, state_d;
  parse_e parse_q, parse_d;
  logic   accept;
  logic   err_fire;
  err_e   err_code;

  assign in_ready_o = (state_q == S_IDLE) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      parse_q <= P_WAIT_STX;
    end else begin
      state_q <= state_d;
      parse_q <= parse_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    parse_d  = parse_q;
    cmd_o    = '0;
    err_fire = 1'b0;
    err_code = ERR_PARITY;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (sts_i.par_err) begin
            err_fire = 1'b1;
            err_code = ERR_PARITY;
          end else begin
            case (parse_q)
              P_WAIT_STX: begin
                if (sts_i.is_stx) begin
                  parse_d = P_WAIT_LF;
                end
              end
              P_WAIT_LF: begin
                if (sts_i.is_lf) begin
                  cmd_o.fill_clear = 1'b1;
                  parse_d = P_TAG;
                end else if (sts_i.is_etx) begin
                  parse_d = P_WAIT_STX;
                end else begin
                  err_fire = 1'b1;
                  err_code = ERR_FRAMING;
                end
              end
              P_TAG: begin
                if (sts_i.is_split) begin
                  if (sts_i.full) begin
                    err_fire = 1'b1;
                    err_code = ERR_OVERFLOW;
                  end else begin
                    cmd_o.wr_en    = 1'b1;
                    cmd_o.tab_load = 1'b1;
                    parse_d = P_REST;
                  end
                end else if (sts_i.tag_full) begin
                  err_fire = 1'b1;
                  err_code = ERR_TAG_LONG;
                end else if (sts_i.full) begin
                  err_fire = 1'b1;
                  err_code = ERR_OVERFLOW;
                end else begin
                  cmd_o.wr_en = 1'b1;
                end
              end
              P_REST: begin
                if (sts_i.is_cr) begin
                  cmd_o.scan_start = 1'b1;
                  state_d = S_SCAN;
                end else if (sts_i.full) begin
                  err_fire = 1'b1;
                  err_code = ERR_OVERFLOW;
                end else begin
                  cmd_o.wr_en = 1'b1;
                end
              end
              default: parse_d = P_WAIT_STX;
            endcase
          end
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = S_CHECK;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_CHECK: begin
        if (sts_i.short_err || sts_i.cks_err) begin
          if (sts_i.out_free) begin
            err_fire = 1'b1;
            err_code = ERR_CHECKSUM;
            state_d  = S_IDLE;
          end
        end else if (sts_i.tok_err) begin
          if (sts_i.out_free) begin
            err_fire = 1'b1;
            err_code = ERR_TOKEN_COUNT;
            state_d  = S_IDLE;
          end
        end else begin
          cmd_o.name_init = 1'b1;
          state_d = S_NAME_RD;
        end
      end
      S_NAME_RD: begin
        if (sts_i.emit_more) begin
          cmd_o.rd_step = 1'b1;
          state_d = S_NAME_WR;
        end else begin
          cmd_o.data_init = 1'b1;
          state_d = S_DATA_RD;
        end
      end
      S_NAME_WR: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KIND_NAME;
          state_d = S_NAME_RD;
        end
      end
      S_DATA_RD: begin
        if (sts_i.emit_more) begin
          cmd_o.rd_step = 1'b1;
          state_d = S_DATA_WR;
        end else if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KIND_END;
          cmd_o.out_last = 1'b1;
          parse_d = P_WAIT_LF;
          state_d = S_IDLE;
        end
      end
      S_DATA_WR: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KIND_DATA;
          state_d = S_DATA_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Every error is a single result beat and drops back to waiting for STX.
    if (err_fire) begin
      cmd_o.out_load = 1'b1;
      cmd_o.out_kind = KIND_ERR;
      cmd_o.out_err  = err_code;
      cmd_o.out_last = 1'b1;
      parse_d = P_WAIT_STX;
    end
  end

  a_cr_starts_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.scan_start |=> (state_q == S_SCAN))
    else $error("scan start did not enter the scan");

  a_end_after_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && (cmd_o.out_kind == KIND_END)) |-> (state_q == S_DATA_RD))
    else $error("end marker issued outside the data phase");

  a_busy_parse_rest : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (parse_q == P_REST))
    else $error("dataset sequencer running outside the dataset body");

endmodule

// ----- src/teleinfo_dataset_parser.sv -----
// Teleinfo dataset parser, top level. A byte that yields no result or a single
// error needs no sequencing; its result beat shows in the cycle after it is taken.
// A CR byte runs the checksum scan of the store and a check, then reads and
// emits each name character, then each data character, then the end marker.
// Reset clears all control state; the store needs no clearing.
module teleinfo_dataset_parser
  import tdp_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 37,
  parameter int unsigned TAG_MAX     = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Received bytes. tdata: rx_byte[7:0] (seven data bits, parity in bit 7).
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Results. tdata: char_value[6:0], error_code[9:7], zero fill [15:10].
  // tuser: kind[1:0]. tlast: last result beat caused by one input byte.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [1:0]             m_axis_tuser,
  output logic                   m_axis_tlast
);

  // The controller owns the frame state and sequences each dataset end; the
  // datapath holds the character store, the scan accumulators and the single
  // output register, which frees the input side as soon as a beat is taken.
  dp_cmd_t           cmd;
  dp_sts_t           sts;
  kind_e             out_kind;
  logic [CHAR_W-1:0] out_char;
  err_e              out_err;

  tdp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  tdp_datapath #(
    .STORE_DEPTH(STORE_DEPTH),
    .TAG_MAX    (TAG_MAX)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_byte_i  (s_axis_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_kind_o (out_kind),
    .out_char_o (out_char),
    .out_err_o  (out_err),
    .out_last_o (m_axis_tlast)
  );

  // Characters and error codes share tdata; kind goes out on tuser.
  assign m_axis_tdata = {{(OUT_TDATA_W - CHAR_W - 3){1'b0}}, out_err, out_char};
  assign m_axis_tuser = out_kind;

endmodule

// ----- test/teleinfo_dataset_parser_test.sv -----
// Self-checking testbench for the teleinfo dataset parser: framed byte streams in, result beats out.
// Depends on tdp_pkg and teleinfo_dataset_parser only; a scoreboard class predicts every beat.
module teleinfo_dataset_parser_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tdp_pkg::*;

  localparam int unsigned STORE_DEPTH = 37;
  localparam int unsigned TAG_MAX     = 8;
  // Roughly the number of bytes that do some work in the random part.
  localparam int unsigned RX_TARGET   = 330;
  // The longest dataset takes a scan of the full store and then a read and a load
  // per emitted character, and this tail covers any such work.
  localparam int unsigned TAIL_CYCLES = 200;
  // The longest quiet spell of a correct run is the checksum scan of a full
  // store plus a long random stall; this is many times that.
  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct {
    kind_e             kind;
    logic [CHAR_W-1:0] ch;
    logic [2:0]        code;
    logic              last;
  } out_beat_t;

  // Ways in which a random dataset is spoiled on purpose.
  typedef enum int {
    FLAW_NONE,
    FLAW_CHECKSUM,
    FLAW_PARITY,
    FLAW_SPLITTERS,
    FLAW_TAG,
    FLAW_OVERFLOW,
    FLAW_FRAMING
  } flaw_e;

  // Tracks the parser state for every byte taken, holds the beats that this
  // byte must cause and compares them with what comes out.
  class dataset_beat_board;
    parse_e            phase;
    logic [CHAR_W-1:0] store [STORE_DEPTH];
    int unsigned       fill;
    bit                tab_mode;
    out_beat_t         fresh[$];
    out_beat_t         beats_due[$];
    int unsigned       n_bytes, n_live, n_beats, n_sets, n_mism;
    int unsigned       err_seen [7];

    function new();
      phase    = P_WAIT_STX;
      fill     = 0;
      tab_mode = 1'b0;
    endfunction

    function void emit(kind_e kind, logic [CHAR_W-1:0] ch, logic [2:0] code);
      out_beat_t b;
      b.kind = kind;
      b.ch   = ch;
      b.code = code;
      b.last = 1'b0;
      fresh.push_back(b);
    endfunction

    // Any error is a single beat and throws the parser back to frame start.
    function void abort(err_e code);
      emit(KIND_ERR, '0, code);
      err_seen[code]++;
      phase = P_WAIT_STX;
    endfunction

    function bit keep_char(logic [CHAR_W-1:0] ch);
      if (fill >= STORE_DEPTH) return 1'b0;
      store[fill] = ch;
      fill++;
      return 1'b1;
    endfunction

    function int unsigned due_count();
      return beats_due.size();
    endfunction

    function void note_rx_byte(logic [7:0] b);
      logic [CHAR_W-1:0] rx;
      logic [CHAR_W-1:0] split;
      int unsigned       sum, covered, cnt, d_lo, d_hi;
      int unsigned       pos [3];
      out_beat_t         tail;
      rx  = b[CHAR_W-1:0];
      pos = '{0, 0, 0};
      n_bytes++;
      fresh.delete();
      if (^b || phase != P_WAIT_STX || rx == CH_STX) n_live++;
      if (^b) begin
        abort(ERR_PARITY);
      end else begin
        case (phase)
          P_WAIT_STX: begin
            if (rx == CH_STX) phase = P_WAIT_LF;
          end
          P_WAIT_LF: begin
            if (rx == CH_LF) begin
              fill  = 0;
              phase = P_TAG;
            end else if (rx == CH_ETX) begin
              phase = P_WAIT_STX;
            end else begin
              abort(ERR_FRAMING);
            end
          end
          P_TAG: begin
            if (rx == CH_HT || rx == CH_SP) begin
              if (!keep_char(rx)) begin
                abort(ERR_OVERFLOW);
              end else begin
                tab_mode = (rx == CH_HT);
                phase    = P_REST;
              end
            end else if (fill >= TAG_MAX) begin
              abort(ERR_TAG_LONG);
            end else if (!keep_char(rx)) begin
              abort(ERR_OVERFLOW);
            end
          end
          default: begin
            if (rx != CH_CR) begin
              if (!keep_char(rx)) abort(ERR_OVERFLOW);
            end else if (fill < (tab_mode ? 1 : 2)) begin
              // Too short to hold a checksum in space mode.
              abort(ERR_CHECKSUM);
            end else begin
              covered = tab_mode ? fill - 1 : fill - 2;
              sum     = 0;
              for (int unsigned i = 0; i < covered; i++) sum += 32'(store[i]);
              if (CHAR_W'(sum % 64) + CKS_OFFSET != store[fill-1]) begin
                abort(ERR_CHECKSUM);
              end else begin
                split = tab_mode ? CH_HT : CH_SP;
                cnt   = 0;
                for (int unsigned i = 0; i + 1 < fill; i++) begin
                  if (store[i] == split) begin
                    if (cnt < 3) pos[cnt] = i;
                    cnt++;
                  end
                end
                if (cnt != 2 && cnt != 3) begin
                  abort(ERR_TOKEN_COUNT);
                end else begin
                  // With three splitters the timestamp field is skipped.
                  d_lo = (cnt == 2) ? pos[0] + 1 : pos[1] + 1;
                  d_hi = (cnt == 2) ? pos[1] : pos[2];
                  for (int unsigned i = 0; i < pos[0]; i++) emit(KIND_NAME, store[i], '0);
                  for (int unsigned i = d_lo; i < d_hi; i++) emit(KIND_DATA, store[i], '0);
                  emit(KIND_END, '0, '0);
                  n_sets++;
                  phase = P_WAIT_LF;
                end
              end
            end
          end
        endcase
      end
      if (fresh.size() > 0) begin
        tail      = fresh.pop_back();
        tail.last = 1'b1;
        fresh.push_back(tail);
        foreach (fresh[i]) beats_due.push_back(fresh[i]);
      end
    endfunction

    function void flag(string what);
      n_mism++;
      if (n_mism <= 10) $display("[%0t] mismatch: %s", $time, what);
    endfunction

    function void check_out_beat(logic [1:0] kind, logic [CHAR_W-1:0] ch, logic [2:0] code,
                                 logic last);
      out_beat_t want;
      n_beats++;
      if (beats_due.size() == 0) begin
        flag($sformatf("unexpected beat kind %0d char %02h code %0d last %0d",
                       kind, ch, code, last));
      end else begin
        want = beats_due.pop_front();
        if (want.kind !== kind || want.ch !== ch || want.code !== code || want.last !== last)
          flag($sformatf("expected kind %0d char %02h code %0d last %0d, got %0d %02h %0d %0d",
                         want.kind, want.ch, want.code, want.last, kind, ch, code, last));
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]             m_axis_tuser;
  logic                   m_axis_tlast;

  dataset_beat_board board;
  int unsigned       src_idle_pct;
  int unsigned       sink_stall_pct;

  teleinfo_dataset_parser #(
    .STORE_DEPTH (STORE_DEPTH),
    .TAG_MAX     (TAG_MAX)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Result side: tready is redrawn at every falling edge, so stalls can land on
  // any cycle of the emission sequence.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Every beat taken on the result side is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_out_beat(m_axis_tuser, m_axis_tdata[6:0], m_axis_tdata[9:7], m_axis_tlast);
  end

  // Watchdog: ends the run once nothing moves on either side for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("[%0t] watchdog: no beat accepted for %0d cycles", $time, STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // Offers one byte. Entered at a falling edge; returns at the falling edge
  // after the byte was taken, with tvalid still high so that back-to-back
  // bytes never see a low pulse.
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_rx_byte(b);
    @(negedge clk_i);
  endtask

  // Sends a character with correct (even) parity in bit 7.
  task automatic push_char(input logic [CHAR_W-1:0] ch);
    push_byte({^ch, ch});
  endtask

  // Sends a dataset body; the character at bad_at, if any, gets wrong parity.
  task automatic send_chars(input logic [CHAR_W-1:0] q[$], input int bad_at);
    foreach (q[i]) push_byte({(i == bad_at) ? ~^q[i] : ^q[i], q[i]});
  endtask

  task automatic pause_until_drained();
    s_axis_tvalid = 1'b0;
    while (board.due_count() != 0) @(negedge clk_i);
  endtask

  function automatic void add_checksum(ref logic [CHAR_W-1:0] q[$], input bit tab);
    int unsigned sum;
    sum = 0;
    // Tab mode covers the last splitter, space mode stops just before it.
    for (int i = 0; i < q.size() - (tab ? 0 : 1); i++) sum += 32'(q[i]);
    q.push_back(CHAR_W'(sum % 64) + CKS_OFFSET);
  endfunction

  // Mostly printable characters, now and then any code; never CR or the
  // active splitter, and in the tag neither splitter.
  function automatic logic [CHAR_W-1:0] pick_char(input bit in_tag, input bit tab);
    logic [CHAR_W-1:0] c;
    do begin
      c = ($urandom_range(9) == 0) ? CHAR_W'($urandom_range(127))
                                   : CHAR_W'($urandom_range(8'h21, 8'h7E));
    end while (c == CH_CR || c == (tab ? CH_HT : CH_SP)
               || (in_tag && (c == CH_HT || c == CH_SP)));
    return c;
  endfunction

  function automatic void build_set(ref logic [CHAR_W-1:0] q[$], input int tag_len,
                                    input bit tab, input int ts_len, input int data_len,
                                    input int extra_split);
    logic [CHAR_W-1:0] split;
    int                first_split;
    split = tab ? CH_HT : CH_SP;
    q.delete();
    repeat (tag_len) q.push_back(pick_char(1'b1, tab));
    first_split = q.size();
    q.push_back(split);
    if (ts_len >= 0) begin
      repeat (ts_len) q.push_back(pick_char(1'b0, tab));
      q.push_back(split);
    end
    repeat (data_len) q.push_back(pick_char(1'b0, tab));
    repeat (extra_split) q.insert($urandom_range(first_split + 1, q.size()), split);
    q.push_back(split);
    add_checksum(q, tab);
  endfunction

  // One frame: STX, one to three datasets, ETX. Most datasets are clean;
  // the rest carry one deliberate flaw. Stray bytes sometimes precede it.
  task automatic random_frame();
    logic [CHAR_W-1:0] q[$];
    flaw_e             flaw;
    bit                tab;
    int                tag_len, ts_len, data_len, extra, bad_at;
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)));
    push_char(CH_STX);
    repeat ($urandom_range(1, 3)) begin
      flaw     = ($urandom_range(99) < 65) ? FLAW_NONE : flaw_e'($urandom_range(1, 6));
      tab      = 1'($urandom_range(1));
      tag_len  = $urandom_range(0, TAG_MAX);
      ts_len   = ($urandom_range(2) == 0) ? $urandom_range(0, 12) : -1;
      data_len = $urandom_range(0, 12);
      extra    = 0;
      bad_at   = -1;
      case (flaw)
        FLAW_SPLITTERS: extra = $urandom_range(1, 3);
        FLAW_TAG:       tag_len = $urandom_range(TAG_MAX + 1, TAG_MAX + 4);
        FLAW_OVERFLOW: begin
          ts_len   = -1;
          data_len = $urandom_range(STORE_DEPTH, STORE_DEPTH + 4);
        end
        default: ;
      endcase
      build_set(q, tag_len, tab, ts_len, data_len, extra);
      if (flaw == FLAW_CHECKSUM) q[q.size()-1] ^= 7'h01;
      if (flaw == FLAW_PARITY) bad_at = $urandom_range(0, q.size() - 1);
      push_char(CH_LF);
      send_chars(q, bad_at);
      push_char(CH_CR);
      // Neither LF nor ETX after a dataset is a framing error.
      if (flaw == FLAW_FRAMING) push_char(CHAR_W'($urandom_range(8'h41, 8'h5A)));
    end
    push_char(CH_ETX);
  endtask

  initial begin
    logic [CHAR_W-1:0] q[$];
    board          = new();
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. Stray bytes at both extremes are ignored before a frame
    // starts; a high bit that breaks parity and a low one that does both
    // give a parity error.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h80);
    push_byte(8'h01);
    // Something other than LF or ETX after STX.
    push_char(CH_STX);
    push_char(7'h51);
    // A lone space before CR is too short to carry a checksum.
    push_char(CH_STX);
    push_char(CH_LF);
    push_char(CH_SP);
    push_char(CH_CR);
    // Tab mode with a timestamp and control characters in the data.
    q = '{7'h41, CH_HT, 7'h7F, CH_HT, 7'h00, 7'h01, CH_HT};
    add_checksum(q, 1'b1);
    push_char(CH_STX);
    push_char(CH_LF);
    send_chars(q, -1);
    push_char(CH_CR);
    push_char(CH_ETX);

    // Random part in four idling phases; between phases the sender waits
    // until every predicted beat has arrived.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 49; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 49; end
        default: begin src_idle_pct = 36; sink_stall_pct = 36; end
      endcase
      while (board.n_live < (ph + 1) * RX_TARGET / 4) random_frame();
      pause_until_drained();
    end

    repeat (TAIL_CYCLES) @(negedge clk_i);
    $display("Sent %0d bytes (%0d not ignored); checked %0d result beats, %0d datasets.",
             board.n_bytes, board.n_live, board.n_beats, board.n_sets);
    $display("Errors: parity %0d framing %0d tag %0d checksum %0d tokens %0d overflow %0d.",
             board.err_seen[ERR_PARITY], board.err_seen[ERR_FRAMING],
             board.err_seen[ERR_TAG_LONG], board.err_seen[ERR_CHECKSUM],
             board.err_seen[ERR_TOKEN_COUNT], board.err_seen[ERR_OVERFLOW]);
    if (board.n_mism == 0 && board.due_count() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d beats still due", board.n_mism, board.due_count());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
